// ----- src/kway_merge_min_select_macros.svh -----
// Assertion macros used by the merge block checker.
// No dependencies; include by bare file name inside a module body.
`ifndef KWAY_MERGE_MIN_SELECT_MACROS_SVH
`define KWAY_MERGE_MIN_SELECT_MACROS_SVH

// same-cycle implication, reset disables the check
`define KMMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disables the check
`define KMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kmms_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the k-way merge block: field widths, packing and defaults.
// No dependencies.
package kmms_pkg;

    localparam int DEF_WAYS    = 8;
    localparam int VAL_W       = 32;
    localparam int WAY_W       = 3;
    localparam int CFG_W       = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

endpackage

// ----- src/kmms_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/kway_merge_min_select.sv -----
`timescale 1ns / 1ps
// K-way merge: takes one word per handshake, returns the smallest held head word.
// Uses kmms_pkg and kmms_ram (head word store).
//
// One input word is taken at a time. After the word is taken the flags are
// checked in the check state; if every active way holds a head or has ended
// and at least one head is held, the head store is read one way per cycle and
// the smallest head then goes to the output register. When every active way
// has ended and no head is held, the all_done word goes there instead; after a
// word that yields nothing the input opens again. The output register lets the
// next word enter while the result waits; a second result waits until the
// first is taken. The final word with all_done set carries zero value and way.
module kway_merge_min_select #(
    parameter int WAYS = kmms_pkg::DEF_WAYS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kmms_pkg::IN_TDATA_W-1:0]    s_tdata,  // src_way[2:0], in_value[34:3]
    input  logic                               s_tlast,  // stream_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kmms_pkg::OUT_TDATA_W-1:0]   m_tdata,  // out_value[31:0], out_way[34:32]
    output logic                               m_tuser,  // all_done
    input  logic                               active_ways_we,
    input  logic [kmms_pkg::CFG_W-1:0]         active_ways_wdata
);
    import kmms_pkg::*;

    localparam int IDXW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNTW = $clog2(WAYS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  active_reg, active_next;
    logic [WAYS-1:0]   loaded_reg, loaded_next;
    logic [WAYS-1:0]   ended_reg, ended_next;
    logic [CNTW-1:0]   ptr_reg, ptr_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDXW-1:0]   pend_idx_reg, pend_idx_next;
    logic              best_any_reg, best_any_next;
    logic [VAL_W-1:0]  best_val_reg, best_val_next;
    logic [IDXW-1:0]   best_idx_reg, best_idx_next;
    logic              done_reg, done_next;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic [WAY_W-1:0]  m_way_reg, m_way_next;
    logic              m_done_reg, m_done_next;

    logic [CNTW-1:0]   live_n;
    logic [WAY_W-1:0]  in_way;
    logic [VAL_W-1:0]  in_value;
    logic              s_acc;
    logic              way_ok;
    logic [IDXW-1:0]   idx_in;
    logic [WAYS-1:0]   act_mask;
    logic              ready_all;
    logic              any_loaded;
    logic              ram_we;
    logic              ram_re;
    logic [IDXW-1:0]   ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    assign in_way   = s_tdata[WAY_W-1:0];
    assign in_value = s_tdata[WAY_W+VAL_W-1:WAY_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign idx_in   = IDXW'(in_way);

    always_comb
    begin
        if (active_reg == '0)
        begin
            live_n = CNTW'(1);
        end
        else if (32'(active_reg) > WAYS)
        begin
            live_n = CNTW'(WAYS);
        end
        else
        begin
            live_n = CNTW'(active_reg);
        end
    end

    assign way_ok = (32'(in_way) < 32'(live_n)) && !ended_reg[idx_in];
    assign ram_we = s_acc && way_ok && !s_tlast && !loaded_reg[idx_in];

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            act_mask[i] = (i < 32'(live_n));
        end
    end

    assign ready_all  = &(~act_mask | loaded_reg | ended_reg);
    assign any_loaded = |(act_mask & loaded_reg);

    assign ram_re    = (state_reg == ST_SCAN) && (ptr_reg < live_n);
    assign ram_raddr = IDXW'(ptr_reg);

    kmms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WAYS)
    ) u_head_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_in),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        loaded_next     = loaded_reg;
        ended_next      = ended_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_any_next   = best_any_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        done_next       = done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_value_next    = m_value_reg;
        m_way_next      = m_way_reg;
        m_done_next     = m_done_reg;

        if (active_ways_we)
        begin
            active_next = active_ways_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (way_ok)
                    begin
                        if (s_tlast)
                        begin
                            ended_next[idx_in] = 1'b1;
                        end
                        else
                        begin
                            loaded_next[idx_in] = 1'b1;
                        end
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!ready_all)
                begin
                    state_next = ST_IDLE;
                end
                else if (any_loaded)
                begin
                    ptr_next      = '0;
                    best_any_next = 1'b0;
                    done_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                // compare the word read in the previous cycle
                if (pend_valid_reg && loaded_reg[pend_idx_reg]
                    && (!best_any_reg || (ram_rdata < best_val_reg)))
                begin
                    best_any_next = 1'b1;
                    best_val_next = ram_rdata;
                    best_idx_next = pend_idx_reg;
                end
                if (ptr_reg == live_n)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = IDXW'(ptr_reg);
                    ptr_next        = ptr_reg + CNTW'(1);
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_done_next  = done_reg;
                    if (done_reg)
                    begin
                        m_value_next = '0;
                        m_way_next   = '0;
                    end
                    else
                    begin
                        m_value_next              = best_val_reg;
                        m_way_next                = WAY_W'(best_idx_reg);
                        loaded_next[best_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= ACTIVE_RESET;
            loaded_reg     <= '0;
            ended_reg      <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            best_any_reg   <= 1'b0;
            done_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            loaded_reg     <= loaded_next;
            ended_reg      <= ended_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            best_any_reg   <= best_any_next;
            done_reg       <= done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        m_value_reg  <= m_value_next;
        m_way_reg    <= m_way_next;
        m_done_reg   <= m_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_done_reg;
    assign m_tdata  = {{(OUT_TDATA_W-VAL_W-WAY_W){1'b0}}, m_way_reg, m_value_reg};

endmodule

// ----- src/kmms_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the k-way merge block, bound to the top level.
// Uses kmms_pkg and kway_merge_min_select_macros.svh.
module kmms_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [kmms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                               m_tuser
);
    import kmms_pkg::*;
    `include "kway_merge_min_select_macros.svh"

    // stalled result holds
    `KMMS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // final word carries zero value and way
    `KMMS_ASSERT_SAME(a_done_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0, "done word not zero")

    // one word in flight: the input closes right after a word is taken
    `KMMS_ASSERT_NEXT(a_one_at_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input open after accept")

    // a result never appears in the cycle after a word was taken
    `KMMS_ASSERT_SAME(a_out_latency, clk, rst_n, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result too early")

endmodule

bind kway_merge_min_select kmms_checker u_kmms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
